/* rtl/cfcf_pkg.sv */
// Package for the CAN-FD frame change filter: identifier constants, cache geometry,
// frame status and verdict codes, and the frame classification and cache reset functions.
// Depends on nothing; used by can_frame_change_filter_core.
package cfcf_pkg;

  // Cache geometry: fourteen slots of eight 64-bit words, addressed as {slot, word}.
  localparam int unsigned FRAME_WORDS_DEF = 8;
  localparam int unsigned NUM_SLOTS       = 14;
  localparam int unsigned SLOT_STRIDE     = 8;
  localparam int unsigned CACHE_DEPTH     = NUM_SLOTS * SLOT_STRIDE;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned ID_W            = 29;
  localparam int unsigned WORD_IDX_W      = 3;
  localparam int unsigned SLOT_W          = 4;
  localparam int unsigned CACHE_AW        = SLOT_W + WORD_IDX_W;
  localparam int unsigned VERDICT_W       = 3;

  // Tracked identifiers with one slot each.
  localparam logic [ID_W-1:0] ID_SINGLE_0 = 29'h180110E4;
  localparam logic [ID_W-1:0] ID_SINGLE_1 = 29'h180210E4;
  localparam logic [ID_W-1:0] ID_SINGLE_2 = 29'h180310E4;
  // Paged identifiers; the page number is payload byte 0.
  localparam logic [ID_W-1:0] ID_PAGED_A  = 29'h1A0110E4;
  localparam logic [ID_W-1:0] ID_PAGED_B  = 29'h1B0110E4;
  localparam logic [ID_W-1:0] ID_PAGED_C  = 29'h180410E4;
  // Exclusion list.
  localparam logic [ID_W-1:0] ID_EXCL_BYTE = 29'h1CB0E410;
  localparam logic [7:0]      EXCL_BYTE0   = 8'hC9;
  localparam logic [ID_W-1:0] ID_EXCL_0    = 29'h1CB010E4;
  localparam logic [ID_W-1:0] ID_EXCL_1    = 29'h1823E410;
  localparam logic [ID_W-1:0] ID_EXCL_NULL = 29'h0;

  // Slot numbers and page counts.
  localparam logic [SLOT_W-1:0] SLOT_SINGLE_0 = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_SINGLE_1 = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_SINGLE_2 = 4'd2;
  localparam logic [SLOT_W-1:0] BASE_PAGED_A  = 4'd3;
  localparam logic [SLOT_W-1:0] BASE_PAGED_B  = 4'd11;
  localparam logic [SLOT_W-1:0] BASE_PAGED_C  = 4'd13;
  localparam logic [SLOT_W-1:0] PAGES_A       = 4'd8;
  localparam logic [SLOT_W-1:0] PAGES_B       = 4'd2;
  localparam logic [SLOT_W-1:0] PAGES_C       = 4'd1;

  // Status of the open frame.
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_EXCLUDED  = 3'd1,
    ST_UNTRACKED = 3'd2,
    ST_BADPAGE   = 3'd3,
    ST_TRACKED   = 3'd4
  } frame_status_e;

  // Verdict reported with each result.
  typedef enum logic [VERDICT_W-1:0] {
    V_CHANGED   = 3'd0,
    V_EXCLUDED  = 3'd1,
    V_UNTRACKED = 3'd2,
    V_BADPAGE   = 3'd3,
    V_UNCHANGED = 3'd4
  } verdict_e;

  typedef struct packed {
    frame_status_e     status;
    logic [SLOT_W-1:0] slot;
  } frame_class_t;

  // Classifies a new frame from its identifier and payload byte 0.
  function automatic frame_class_t classify(logic [ID_W-1:0] id, logic [7:0] b0);
    frame_class_t      r;
    logic              paged;
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] pages;
    r.status = ST_UNTRACKED;
    r.slot   = '0;
    paged    = 1'b0;
    base     = '0;
    pages    = '0;
    priority if ((id == ID_EXCL_BYTE && b0 == EXCL_BYTE0) || id == ID_EXCL_0 ||
                 id == ID_EXCL_1 || id == ID_EXCL_NULL) begin
      r.status = ST_EXCLUDED;
    end else if (id == ID_SINGLE_0) begin
      r.status = ST_TRACKED;
      r.slot   = SLOT_SINGLE_0;
    end else if (id == ID_SINGLE_1) begin
      r.status = ST_TRACKED;
      r.slot   = SLOT_SINGLE_1;
    end else if (id == ID_SINGLE_2) begin
      r.status = ST_TRACKED;
      r.slot   = SLOT_SINGLE_2;
    end else if (id == ID_PAGED_A) begin
      paged = 1'b1;
      base  = BASE_PAGED_A;
      pages = PAGES_A;
    end else if (id == ID_PAGED_B) begin
      paged = 1'b1;
      base  = BASE_PAGED_B;
      pages = PAGES_B;
    end else if (id == ID_PAGED_C) begin
      paged = 1'b1;
      base  = BASE_PAGED_C;
      pages = PAGES_C;
    end else begin
      r.status = ST_UNTRACKED;
    end
    // Pages are numbered from one; zero or beyond the page count is out of range.
    if (paged) begin
      if (b0 == 8'd0 || b0 > {4'd0, pages}) begin
        r.status = ST_BADPAGE;
      end else begin
        r.status = ST_TRACKED;
        r.slot   = base + b0[SLOT_W-1:0] - 4'd1;
      end
    end
    return r;
  endfunction

  // Value of a cache word after reset: word 0 of a paged slot holds its page number.
  function automatic logic [DATA_W-1:0] cache_reset_word(logic [CACHE_AW-1:0] addr);
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] page;
    logic [DATA_W-1:0] r;
    slot = addr[CACHE_AW-1:WORD_IDX_W];
    page = '0;
    if (addr[WORD_IDX_W-1:0] == '0) begin
      priority if (slot >= BASE_PAGED_C) begin
        page = slot - BASE_PAGED_C + 4'd1;
      end else if (slot >= BASE_PAGED_B) begin
        page = slot - BASE_PAGED_B + 4'd1;
      end else if (slot >= BASE_PAGED_A) begin
        page = slot - BASE_PAGED_A + 4'd1;
      end else begin
        page = '0;
      end
    end
    r = {{(DATA_W-SLOT_W){1'b0}}, page};
    return r;
  endfunction

endpackage

/* rtl/cfcf_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; the filter keeps its payload cache in one instance.
module cfcf_ram #(
  parameter int unsigned DataWidth = 64,
  parameter int unsigned Depth     = 112,
  localparam int unsigned AddrW    = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [DataWidth-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/can_frame_change_filter_core.sv */
// Top level of the CAN-FD frame change filter: frame sequencing, cache compare and
// write-back, result register. Depends on cfcf_pkg and cfcf_ram.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_ready_o can_id_i, word_index_i, data_word_i
//   out      output     out_valid_o/out_ready_i log_frame_o, verdict_o, cache_slot_o
//
// A word is accepted and its cached copy read from the RAM; the next cycle compares it
// against that copy and writes it back; words stream at one per cycle unless held off.
// After the last word of a frame the input holds off while the result is formed in the
// compare stage, and it also waits while the result register is full.
// Back-to-back accesses to the same cache word are forwarded around the RAM.
// Reset clears the frame state and the per-word valid bits; no clearing pass is needed.
module can_frame_change_filter_core #(
  parameter int unsigned FRAME_WORDS = cfcf_pkg::FRAME_WORDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cfcf_pkg::ID_W-1:0]           can_id_i,
  input  logic [cfcf_pkg::WORD_IDX_W-1:0]     word_index_i,
  input  logic [cfcf_pkg::DATA_W-1:0]         data_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                log_frame_o,
  output logic [cfcf_pkg::VERDICT_W-1:0]      verdict_o,
  output logic [cfcf_pkg::SLOT_W-1:0]         cache_slot_o
);

  localparam int unsigned IdxW  = cfcf_pkg::WORD_IDX_W;
  localparam int unsigned SlotW = cfcf_pkg::SLOT_W;
  localparam int unsigned Aw    = cfcf_pkg::CACHE_AW;
  localparam int unsigned Dw    = cfcf_pkg::DATA_W;
  localparam logic [IdxW:0] LastWord = (IdxW+1)'(FRAME_WORDS - 1);

  // Frame sequencing state.
  cfcf_pkg::frame_status_e status_q, status_d;
  logic [SlotW-1:0]        slot_q, slot_d;
  logic [IdxW-1:0]         exp_q, exp_d;

  // Compare stage.
  logic                    b_valid_q;
  logic                    b_first_q, b_last_q;
  cfcf_pkg::frame_status_e b_status_q;
  logic [SlotW-1:0]        b_slot_q;
  logic [IdxW-1:0]         b_word_q;
  logic [Dw-1:0]           b_data_q;
  logic                    differs_q, differs_d;

  // Cache side.
  logic [cfcf_pkg::CACHE_DEPTH-1:0] valid_q;
  logic                             vld_rd_q;
  logic                             fwd_hit_q;
  logic [Dw-1:0]                    fwd_data_q;
  logic                             ram_we, ram_re;
  logic [Aw-1:0]                    ram_waddr, ram_raddr;
  logic [Dw-1:0]                    ram_rdata;

  // Result register.
  logic                          out_valid_q;
  logic                          log_q;
  logic [cfcf_pkg::VERDICT_W-1:0] verdict_q;
  logic [SlotW-1:0]              cslot_q;

  logic                    in_acc, in_range, is_first, is_last, in_seq, take;
  cfcf_pkg::frame_class_t  cls;
  cfcf_pkg::frame_status_e cur_status;
  logic [SlotW-1:0]        cur_slot;
  logic [Dw-1:0]           old_word;
  logic                    mismatch, diff_acc, emit;
  cfcf_pkg::verdict_e      verdict_c;

  // Input acceptance: hold off while a result is forming or cannot be stored.
  assign in_ready_o = (!out_valid_q || out_ready_i) && !(b_valid_q && b_last_q);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, word_index_i} <= LastWord;
  assign is_first   = word_index_i == '0;
  assign is_last    = {1'b0, word_index_i} == LastWord;
  assign in_seq     = (status_q != cfcf_pkg::ST_IDLE) && (word_index_i == exp_q);
  assign take       = in_acc && in_range && (is_first || in_seq);
  assign cls        = cfcf_pkg::classify(can_id_i, data_word_i[7:0]);
  assign cur_status = is_first ? cls.status : status_q;
  assign cur_slot   = is_first ? cls.slot : slot_q;

  // Next frame state on a word that belongs to the frame.
  always_comb begin
    status_d = status_q;
    slot_d   = slot_q;
    exp_d    = exp_q;
    if (take) begin
      if (is_last) begin
        status_d = cfcf_pkg::ST_IDLE;
        slot_d   = '0;
        exp_d    = '0;
      end else begin
        status_d = cur_status;
        slot_d   = cur_slot;
        exp_d    = word_index_i + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= cfcf_pkg::ST_IDLE;
      slot_q   <= '0;
      exp_q    <= '0;
    end else begin
      status_q <= status_d;
      slot_q   <= slot_d;
      exp_q    <= exp_d;
    end
  end

  // Cache read at acceptance, write-back from the compare stage.
  assign ram_re    = take && (cur_status == cfcf_pkg::ST_TRACKED);
  assign ram_raddr = {cur_slot, word_index_i};
  assign ram_we    = b_valid_q && (b_status_q == cfcf_pkg::ST_TRACKED);
  assign ram_waddr = {b_slot_q, b_word_q};

  cfcf_ram #(
    .DataWidth(Dw),
    .Depth    (cfcf_pkg::CACHE_DEPTH)
  ) u_cache (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(b_data_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Valid bits mark words written since reset; the rest read as their reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[ram_waddr] <= 1'b1;
    end
  end

  // Valid bit and forwarding capture, aligned with the registered RAM read.
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      vld_rd_q   <= valid_q[ram_raddr];
      fwd_hit_q  <= ram_we && (ram_waddr == ram_raddr);
      fwd_data_q <= b_data_q;
    end
  end

  // Compare stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      differs_q <= 1'b0;
    end else begin
      b_valid_q <= take;
      differs_q <= differs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      b_first_q  <= is_first;
      b_last_q   <= is_last;
      b_status_q <= cur_status;
      b_slot_q   <= cur_slot;
      b_word_q   <= word_index_i;
      b_data_q   <= data_word_i;
    end
  end

  // Compare against the cached word and accumulate the frame's change flag.
  always_comb begin
    priority if (fwd_hit_q) begin
      old_word = fwd_data_q;
    end else if (vld_rd_q) begin
      old_word = ram_rdata;
    end else begin
      old_word = cfcf_pkg::cache_reset_word(ram_waddr);
    end
    mismatch  = (b_status_q == cfcf_pkg::ST_TRACKED) && (old_word != b_data_q);
    diff_acc  = (b_first_q ? 1'b0 : differs_q) | mismatch;
    differs_d = differs_q;
    if (b_valid_q) begin
      differs_d = b_last_q ? 1'b0 : diff_acc;
    end
    emit = b_valid_q && b_last_q;
  end

  // Verdict for a completed frame.
  always_comb begin
    unique case (b_status_q)
      cfcf_pkg::ST_TRACKED:   verdict_c = diff_acc ? cfcf_pkg::V_CHANGED : cfcf_pkg::V_UNCHANGED;
      cfcf_pkg::ST_EXCLUDED:  verdict_c = cfcf_pkg::V_EXCLUDED;
      cfcf_pkg::ST_UNTRACKED: verdict_c = cfcf_pkg::V_UNTRACKED;
      cfcf_pkg::ST_BADPAGE:   verdict_c = cfcf_pkg::V_BADPAGE;
      default:                verdict_c = cfcf_pkg::V_UNTRACKED;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      log_q     <= verdict_c == cfcf_pkg::V_CHANGED;
      verdict_q <= verdict_c;
      cslot_q   <= (b_status_q == cfcf_pkg::ST_TRACKED) ? b_slot_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign log_frame_o  = log_q;
  assign verdict_o    = verdict_q;
  assign cache_slot_o = cslot_q;

`ifndef SYNTH
  // A completing frame always finds room in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_last_q) |-> (!out_valid_q || out_ready_i))
    else $error("result formed while result register is occupied");

  // An expected word index other than zero only exists inside an open frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != '0) |-> (status_q != cfcf_pkg::ST_IDLE))
    else $error("expected word set with no frame open");

  // Only tracked frames report a cache slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cache_slot_o != '0) |->
      (verdict_o == cfcf_pkg::V_CHANGED || verdict_o == cfcf_pkg::V_UNCHANGED))
    else $error("cache slot reported for an untracked verdict");

  // A cache write-back always comes in the cycle after a cache read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(ram_re))
    else $error("cache write-back without a preceding read");
`endif

endmodule
